// ===== design/hsm_pkg.sv =====
// Shared types and constants for the heartbeat stall monitor.
// No dependencies; imported by every module of the block.
package hsm_pkg;

  localparam int CHAN_W     = 4;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int ACT_W      = 2;
  localparam int HEALTH_W   = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - (CHAN_W + CNT_W + TIME_W + HEALTH_W);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [ACT_W-1:0] ACT_CHECK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BEAT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [HEALTH_W-1:0] HEALTH_OK    = 2'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_SLOW  = 2'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_STALL = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_STALL_LIMIT     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_INTERVAL = 1'b1;

  localparam logic [TIME_W-1:0] STALL_LIMIT_RESET     = 32'd10000;
  localparam logic [TIME_W-1:0] REPORT_INTERVAL_RESET = 32'd5000;

  typedef enum logic [1:0] {
    CMD_BEAT,
    CMD_CLEAR,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAN_W-1:0]  chan;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } back_state_t;

endpackage

// ===== design/hsm_front.sv =====
// Front end: accepts input transfers, drops ignored ones, decides report due.
// Depends on hsm_pkg.
module hsm_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsm_pkg::ACT_W-1:0]   in_action,
  input  logic [hsm_pkg::CHAN_W-1:0]  in_chan,
  input  logic [hsm_pkg::TIME_W-1:0]  in_time,
  input  logic [hsm_pkg::TIME_W-1:0]  report_interval,
  input  logic                        q_full,
  output logic                        q_push,
  output hsm_pkg::cmd_t               q_cmd
);
  import hsm_pkg::*;

  logic [TIME_W-1:0] last_report_r, last_report_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              chan_ok;
  logic              due;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign elapsed  = in_time - last_report_r;
  assign due      = elapsed >= report_interval;
  assign chan_ok  = {1'b0, in_chan} < (CHAN_W + 1)'(NUM_CHANNELS);

  always_comb begin
    q_push          = 1'b0;
    q_cmd.kind      = CMD_BEAT;
    q_cmd.chan      = in_chan;
    q_cmd.now       = in_time;
    last_report_nxt = last_report_r;
    case (in_action)
      ACT_BEAT: begin
        q_push = accept && chan_ok;
      end
      ACT_CLEAR: begin
        q_cmd.kind = CMD_CLEAR;
        q_push     = accept && chan_ok;
      end
      ACT_CHECK: begin
        q_cmd.kind = CMD_REPORT;
        q_push     = accept && due;
        if (accept && due) begin
          last_report_nxt = in_time;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_report_r <= '0;
    end else begin
      last_report_r <= last_report_nxt;
    end
  end

endmodule

// ===== design/hsm_cmdq.sv =====
// Short command queue between front and back end.
// Depends on hsm_pkg.
module hsm_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hsm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output hsm_pkg::cmd_t head
);
  import hsm_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = count_r == (QPTR_W + 1)'(QDEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/hsm_back.sv =====
// Back end: channel slots, beat and clear updates, report scan and output register.
// Depends on hsm_pkg.
module hsm_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  hsm_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [hsm_pkg::TIME_W-1:0]    stall_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsm_pkg::OUT_DATA_W-1:0] out_data,
  output logic                          out_last
);
  import hsm_pkg::*;

  localparam int CIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(NUM_CHANNELS - 1);

  back_state_t             state_r, state_nxt;
  logic [NUM_CHANNELS-1:0] act_r;
  logic [TIME_W-1:0]       beat_time_r [NUM_CHANNELS];
  logic [CNT_W-1:0]        cnt_r [NUM_CHANNELS];
  logic [CIDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;

  logic                    out_valid_r;
  logic [CHAN_W-1:0]       out_chan_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic [TIME_W-1:0]       out_age_r;
  logic [HEALTH_W-1:0]     out_health_r;
  logic                    out_last_r;

  logic [CIDX_W-1:0]       rd_idx;
  logic [CIDX_W-1:0]       cmd_idx;
  logic                    rd_act;
  logic [TIME_W-1:0]       rd_time;
  logic [CNT_W-1:0]        rd_cnt;
  logic [TIME_W-1:0]       age;
  logic [HEALTH_W-1:0]     health;
  logic                    none_above;
  logic                    out_free;
  logic                    out_load;
  logic                    do_beat, do_clear;

  assign cmd_idx    = cmd.chan[CIDX_W-1:0];
  assign rd_idx     = (state_r == ST_SCAN) ? scan_idx_r : cmd_idx;
  assign rd_act     = act_r[rd_idx];
  assign rd_time    = beat_time_r[rd_idx];
  assign rd_cnt     = cnt_r[rd_idx];
  assign age        = now_r - rd_time;
  assign none_above = ((act_r >> scan_idx_r) >> 1) == '0;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (age > stall_limit) begin
      health = HEALTH_STALL;
    end else if (age > (stall_limit >> 1)) begin
      health = HEALTH_SLOW;
    end else begin
      health = HEALTH_OK;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    now_nxt      = now_r;
    cmd_pop      = 1'b0;
    do_beat      = 1'b0;
    do_clear     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_BEAT:  do_beat  = 1'b1;
            CMD_CLEAR: do_clear = 1'b1;
            CMD_REPORT: begin
              now_nxt      = cmd.now;
              scan_idx_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          out_load = rd_act;
          if (scan_idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
      act_r       <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        beat_time_r[i] <= '0;
        cnt_r[i]       <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_beat) begin
        act_r[cmd_idx]       <= 1'b1;
        beat_time_r[cmd_idx] <= cmd.now;
        cnt_r[cmd_idx]       <= rd_cnt + 1'b1;
      end else if (do_clear) begin
        act_r[cmd_idx]       <= 1'b0;
        beat_time_r[cmd_idx] <= '0;
        cnt_r[cmd_idx]       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (out_load) begin
      out_chan_r   <= CHAN_W'(scan_idx_r);
      out_cnt_r    <= rd_cnt;
      out_age_r    <= age;
      out_health_r <= health;
      out_last_r   <= none_above;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_data  = {{OUT_PAD_W{1'b0}}, out_health_r, out_age_r, out_cnt_r, out_chan_r};

  a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !cmd_pop)
    else $error("command popped during report scan");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SCAN) |-> scan_idx_r == '0)
    else $error("report scan did not start at first channel");

  a_load_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == ST_SCAN && rd_act)
    else $error("status loaded outside scan or for inactive channel");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !out_load)
    else $error("pending status overwritten");

endmodule

// ===== design/heartbeat_stall_monitor.sv =====
// Top level of the heartbeat stall monitor: configuration registers and wiring.
// Depends on hsm_pkg, hsm_front, hsm_cmdq and hsm_back.
//
// A user's summary: the input side takes one transfer per cycle while the
// four-entry command queue has room. Beats and channel clears are applied to
// the slot unit as they leave the queue. A check that finds a report due
// leaves the queue and then walks every channel slot, one slot per cycle while
// the output is not stalled, and holds the slot unit until the walk is done;
// checks that are not due and ignored items are dropped in the front end and
// never reach the slot unit. Each status is a transfer on the output with
// tlast set on the final line of a report; a report with no active channel
// sends nothing.
module heartbeat_stall_monitor #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hsm_pkg::IN_DATA_W-1:0]   in_tdata,   // channel, time_ms, zero pad
  input  logic [hsm_pkg::ACT_W-1:0]       in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hsm_pkg::OUT_DATA_W-1:0]  out_tdata,  // report_channel, beat_total, age_ms, health, zero pad
  output logic                            out_tlast,  // last_of_report
  input  logic                            cfg_we,
  input  logic [hsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hsm_pkg::*;

  logic [TIME_W-1:0] stall_limit_r;
  logic [TIME_W-1:0] report_interval_r;
  logic              q_full, q_push, q_pop, q_not_empty;
  cmd_t              q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r     <= STALL_LIMIT_RESET;
      report_interval_r <= REPORT_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STALL_LIMIT:     stall_limit_r     <= cfg_wdata;
        REG_REPORT_INTERVAL: report_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hsm_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_action       (in_tuser),
    .in_chan         (in_tdata[CHAN_W-1:0]),
    .in_time         (in_tdata[CHAN_W+TIME_W-1:CHAN_W]),
    .report_interval (report_interval_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_in)
  );

  hsm_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hsm_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_not_empty),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .stall_limit (stall_limit_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

// ===== tb/heartbeat_stall_monitor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the heartbeat stall monitor: watches the input, output and register ports,
// predicts every status transfer and compares it field by field.
// Depends on hsm_pkg.
module heartbeat_stall_monitor_checker #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hsm_pkg::IN_DATA_W-1:0]   in_tdata,   // channel, time_ms, zero pad
  input  logic [hsm_pkg::ACT_W-1:0]       in_tuser,   // action
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [hsm_pkg::OUT_DATA_W-1:0]  out_tdata,  // report_channel, beat_total, age_ms, health, zero pad
  input  logic                            out_tlast,  // last_of_report
  input  logic                            cfg_we,
  input  logic [hsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              statuses_seen
);
  import hsm_pkg::*;

  typedef struct {
    logic [CHAN_W-1:0]   chan;
    logic [CNT_W-1:0]    beats;
    logic [TIME_W-1:0]   age;
    logic [HEALTH_W-1:0] health;
    logic                last;
  } status_t;

  status_t expected_status[$];

  logic [NUM_CHANNELS-1:0] chan_live;
  logic [TIME_W-1:0]       beat_time  [NUM_CHANNELS];
  logic [CNT_W-1:0]        beat_tally [NUM_CHANNELS];
  logic [TIME_W-1:0]       report_time;
  logic [TIME_W-1:0]       stall_limit;
  logic [TIME_W-1:0]       report_gap;

  initial begin
    fail_count    = 0;
    pending       = 0;
    statuses_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    end
  endtask

  task automatic check_status(input status_t want);
    if (out_tdata[0 +: CHAN_W] !== want.chan)
      report_mismatch("report_channel", 32'(out_tdata[0 +: CHAN_W]), 32'(want.chan));
    if (out_tdata[CHAN_W +: CNT_W] !== want.beats)
      report_mismatch("beat_total", out_tdata[CHAN_W +: CNT_W], want.beats);
    if (out_tdata[CHAN_W + CNT_W +: TIME_W] !== want.age)
      report_mismatch("age_ms", out_tdata[CHAN_W + CNT_W +: TIME_W], want.age);
    if (out_tdata[CHAN_W + CNT_W + TIME_W +: HEALTH_W] !== want.health)
      report_mismatch("health", 32'(out_tdata[CHAN_W + CNT_W + TIME_W +: HEALTH_W]),
                      32'(want.health));
    if (out_tlast !== want.last)
      report_mismatch("last_of_report", 32'(out_tlast), 32'(want.last));
  endtask

  task automatic predict_status(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
                                input logic [TIME_W-1:0] now);
    status_t           s;
    logic [TIME_W-1:0] age;
    int                last_live;
    last_live = -1;
    case (act)
      ACT_BEAT: begin
        if (ch < NUM_CHANNELS) begin
          chan_live[ch]  = 1'b1;
          beat_time[ch]  = now;
          beat_tally[ch] = beat_tally[ch] + 1'b1;
        end
      end
      ACT_CLEAR: begin
        if (ch < NUM_CHANNELS) begin
          chan_live[ch]  = 1'b0;
          beat_time[ch]  = '0;
          beat_tally[ch] = '0;
        end
      end
      ACT_CHECK: begin
        if (TIME_W'(now - report_time) >= report_gap) begin
          report_time = now;
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (chan_live[i]) last_live = i;
          end
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (chan_live[i]) begin
              age      = now - beat_time[i];
              s.chan   = CHAN_W'(i);
              s.beats  = beat_tally[i];
              s.age    = age;
              s.last   = (i == last_live);
              if (age > stall_limit) s.health = HEALTH_STALL;
              else if (age > (stall_limit >> 1)) s.health = HEALTH_SLOW;
              else s.health = HEALTH_OK;
              expected_status.push_back(s);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_live   = '0;
      report_time = '0;
      stall_limit = STALL_LIMIT_RESET;
      report_gap  = REPORT_INTERVAL_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        beat_time[i]  = '0;
        beat_tally[i] = '0;
      end
      expected_status.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected status transfer, channel",
                          32'(out_tdata[0 +: CHAN_W]), 32'(0));
        end else begin
          check_status(expected_status.pop_front());
          statuses_seen++;
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_STALL_LIMIT) stall_limit = cfg_wdata;
        else if (cfg_addr == REG_REPORT_INTERVAL) report_gap = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        predict_status(in_tuser, in_tdata[0 +: CHAN_W], in_tdata[CHAN_W +: TIME_W]);
      end
    end
    pending = expected_status.size();
  end

endmodule

// ===== tb/heartbeat_stall_monitor_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the heartbeat stall monitor: clock, reset, stimulus and verdict.
// Depends on hsm_pkg, heartbeat_stall_monitor and heartbeat_stall_monitor_checker.
module heartbeat_stall_monitor_tb;
  import hsm_pkg::*;

  localparam int               NUM_CHANNELS = 8;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam int               DRAIN_CYCLES = 48;
  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic [ACT_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int                     fail_count;
  int                     pending;
  int                     statuses_seen;
  int                     cycle_count  = 0;
  int                     items_sent   = 0;
  int                     settings     = 1;
  bit                     idle_on      = 1'b1;
  logic [TIME_W-1:0]      now_ms;

  heartbeat_stall_monitor #(.NUM_CHANNELS(NUM_CHANNELS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  heartbeat_stall_monitor_checker #(.NUM_CHANNELS(NUM_CHANNELS)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .statuses_seen (statuses_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d statuses outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // stall the output side in random bursts
  initial begin
    @(negedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (idle_on) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic push_item(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
                           input logic [TIME_W-1:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - CHAN_W - TIME_W){1'b0}}, t, ch};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // drain all statuses, give queued beats time to retire, then reprogram
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] stall,
                             input logic [CFG_DATA_W-1:0] gap);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_STALL_LIMIT, stall);
    write_reg(REG_REPORT_INTERVAL, gap);
    settings++;
  endtask

  task automatic rand_items(input int n, input logic [TIME_W-1:0] step_max);
    int                pick;
    logic [CHAN_W-1:0] ch;
    logic [ACT_W-1:0]  act;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) ch = CHAN_W'($urandom_range(NUM_CHANNELS, 15));
      else ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
      if (pick < 3) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, step_max);
      if (pick < 45) act = ACT_BEAT;
      else if (pick < 55) act = ACT_CLEAR;
      else if (pick < 94) act = ACT_CHECK;
      else act = ACT_UNUSED;
      push_item(act, ch, now_ms);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] gap;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_item(ACT_CHECK, 4'd0, 32'd0);
    push_item(ACT_CHECK, 4'd0, 32'd5000);
    push_item(ACT_BEAT, 4'd0, 32'd5100);
    push_item(ACT_BEAT, 4'd7, 32'd5200);
    push_item(ACT_BEAT, 4'd8, 32'd5300);
    push_item(ACT_BEAT, 4'd15, 32'd5400);
    push_item(ACT_UNUSED, 4'd3, 32'd5500);
    push_item(ACT_CLEAR, 4'd15, 32'd5600);
    push_item(ACT_BEAT, 4'd0, 32'd6000);
    push_item(ACT_CHECK, 4'd0, 32'd10000);
    push_item(ACT_CHECK, 4'd0, 32'd12000);
    push_item(ACT_CHECK, 4'd0, 32'd15000);
    push_item(ACT_BEAT, 4'd7, 32'd19500);
    push_item(ACT_BEAT, 4'd3, 32'd20000);
    push_item(ACT_CHECK, 4'd0, 32'd20001);
    push_item(ACT_BEAT, 4'd5, 32'd25000);
    push_item(ACT_CHECK, 4'd0, 32'd30000);
    push_item(ACT_CLEAR, 4'd0, 32'd30100);
    push_item(ACT_CLEAR, 4'd12, 32'd30200);
    push_item(ACT_BEAT, 4'd1, 32'hFFFF_FFF0);
    push_item(ACT_BEAT, 4'd6, 32'hFFFF_FFFF);
    push_item(ACT_CHECK, 4'd0, 32'h0000_0010);
    now_ms = 32'h0000_0010;

    reconfigure('0, '0);
    rand_items(30, 32'd40);
    reconfigure(32'd1, 32'd1);
    rand_items(30, 32'd3);
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    rand_items(20, 32'hFFFF_FFFF);
    for (int p = 0; p < 4; p++) begin
      gap = $urandom_range(1, 600);
      if (p == 1) reconfigure($urandom, gap);
      else reconfigure($urandom_range(2, 3000), gap);
      if (p == 3) idle_on = 1'b0;
      rand_items(35, gap + (gap >> 1));
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d input transfers over %0d register settings,", items_sent, settings);
    $display("%0d status transfers compared, %0d mismatches.", statuses_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
